/* design/qfp_pkg.sv */
// shared types, codes and helpers for the quic frame header parser
// no dependencies
`default_nettype none
package qfp_pkg;

  localparam int OffsetWidth = 16;
  localparam int ValWidth    = 62;
  localparam int QueueDepth  = 4;
  localparam int QueuePtrW   = $clog2(QueueDepth);

  typedef logic [ValWidth-1:0]    val_t;
  typedef logic [OffsetWidth-1:0] off_t;

  // frame type bytes
  localparam logic [7:0] TYPE_PADDING   = 8'h00;
  localparam logic [7:0] TYPE_PING      = 8'h01;
  localparam logic [7:0] TYPE_ACK       = 8'h02;
  localparam logic [7:0] TYPE_ACK_ECN   = 8'h03;
  localparam logic [7:0] TYPE_CRYPTO    = 8'h06;
  localparam logic [7:0] TYPE_TOKEN     = 8'h07;
  localparam logic [7:0] TYPE_STREAM_LO = 8'h08;
  localparam logic [7:0] TYPE_STREAM_HI = 8'h0f;
  localparam logic [7:0] TYPE_CLOSE     = 8'h1c;
  localparam logic [7:0] TYPE_APP_CLOSE = 8'h1d;
  localparam logic [7:0] TYPE_HS_DONE   = 8'h1e;

  // stream type bits
  localparam int StreamOffBit = 2;
  localparam int StreamLenBit = 1;

  typedef enum logic [3:0] {
    KIND_PAD       = 4'd0,
    KIND_PING      = 4'd1,
    KIND_ACK       = 4'd2,
    KIND_ACK_ECN   = 4'd3,
    KIND_CRYPTO    = 4'd4,
    KIND_TOKEN     = 4'd5,
    KIND_STREAM    = 4'd6,
    KIND_CLOSE     = 4'd7,
    KIND_APP_CLOSE = 4'd8,
    KIND_HS_DONE   = 4'd9,
    KIND_UNKNOWN   = 4'd10
  } kind_t;

  typedef enum logic [4:0] {
    PH_TYPE  = 5'd0,
    PH_PAD   = 5'd1,
    PH_SLOT0 = 5'd2,
    PH_SLOT1 = 5'd3,
    PH_SLOT2 = 5'd4,
    PH_SLOT3 = 5'd5,
    PH_SLOT4 = 5'd6,
    PH_SLOT5 = 5'd7,
    PH_SLOT6 = 5'd8,
    PH_LEN   = 5'd9,
    PH_GAP   = 5'd10,
    PH_RLEN  = 5'd11,
    PH_SKIP  = 5'd12,
    PH_TOEND = 5'd13
  } phase_t;

  typedef enum logic [1:0] {
    RC_MORE,
    RC_DONE,
    RC_ERR,
    RC_UNK
  } rcode_t;

  typedef struct packed {
    kind_t      frame_kind;
    logic [7:0] type_code;
    logic       decode_error;
    val_t       value_a;
    val_t       value_b;
    val_t       value_c;
    val_t       value_d;
    val_t       value_e;
    val_t       value_f;
    val_t       value_g;
    off_t       data_offset;
    off_t       data_length;
  } res_t;

  function automatic kind_t kind_of(input logic [7:0] t);
    kind_t k;
    case (t) inside
      TYPE_PADDING:                     k = KIND_PAD;
      TYPE_PING:                        k = KIND_PING;
      TYPE_ACK:                         k = KIND_ACK;
      TYPE_ACK_ECN:                     k = KIND_ACK_ECN;
      TYPE_CRYPTO:                      k = KIND_CRYPTO;
      TYPE_TOKEN:                       k = KIND_TOKEN;
      [TYPE_STREAM_LO:TYPE_STREAM_HI]:  k = KIND_STREAM;
      TYPE_CLOSE:                       k = KIND_CLOSE;
      TYPE_APP_CLOSE:                   k = KIND_APP_CLOSE;
      TYPE_HS_DONE:                     k = KIND_HS_DONE;
      default:                          k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

/* design/qfp_front.sv */
// byte-wise frame parser: consumes one payload byte per transfer and emits
// zero, one or two result records; depends on qfp_pkg
`default_nettype none
module qfp_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_fire,
  input  wire logic [7:0]        data_byte,
  input  wire logic              last_byte,
  output logic [1:0]             push_cnt,
  output qfp_pkg::res_t          push_r0,
  output qfp_pkg::res_t          push_r1
);
  import qfp_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [7:0] type_r, type_nxt;
  logic [2:0] vleft_r, vleft_nxt;
  val_t       vacc_r, vacc_nxt;
  val_t       held_r [7];
  val_t       held_nxt [7];
  val_t       rleft_r, rleft_nxt;
  off_t       skip_r, skip_nxt;
  off_t       boff_r, boff_nxt;
  off_t       pad_r, pad_nxt;
  off_t       sstart_r, sstart_nxt;
  off_t       slen_r, slen_nxt;
  logic       drop_r, drop_nxt;

  function automatic res_t mk_res(input logic [7:0] tb, input logic err, input off_t pr,
                                  input val_t h [7], input off_t ss, input off_t sl);
    res_t  r;
    kind_t k;
    k = kind_of(tb);
    r = '0;
    r.frame_kind = k;
    r.type_code = tb;
    r.decode_error = err;
    if (!err) begin
      if (k == KIND_PAD) begin
        r.value_a = val_t'(pr);
      end else begin
        r.value_a = h[0];
        r.value_b = h[1];
        r.value_c = h[2];
        r.value_d = h[3];
        r.value_e = h[4];
        r.value_f = h[5];
        r.value_g = h[6];
      end
      if (k >= KIND_ACK && k <= KIND_APP_CLOSE) begin
        r.data_offset = ss;
        r.data_length = sl;
      end
    end
    return r;
  endfunction

  always_comb begin
    off_t       nxt;
    rcode_t     rc;
    logic [2:0] slot;
    logic [1:0] n;
    res_t       rr;
    phase_nxt = phase_r;
    type_nxt = type_r;
    vleft_nxt = vleft_r;
    vacc_nxt = vacc_r;
    held_nxt = held_r;
    rleft_nxt = rleft_r;
    skip_nxt = skip_r;
    pad_nxt = pad_r;
    sstart_nxt = sstart_r;
    slen_nxt = slen_r;
    drop_nxt = drop_r;
    nxt = boff_r + off_t'(1);
    boff_nxt = last_byte ? '0 : nxt;
    rc = RC_MORE;
    slot = '0;
    n = '0;
    rr = '0;
    push_r0 = '0;
    push_r1 = '0;

    if (drop_r) begin
      if (last_byte) drop_nxt = 1'b0;
    end else begin
      if (phase_nxt == PH_PAD) begin
        if (data_byte == TYPE_PADDING) begin
          if (pad_nxt != '1) pad_nxt = pad_nxt + off_t'(1);
        end else begin
          push_r0 = mk_res(type_nxt, 1'b0, pad_nxt, held_nxt, sstart_nxt, slen_nxt);
          n = 2'd1;
          phase_nxt = PH_TYPE;
        end
      end

      if (phase_nxt == PH_TYPE) begin
        type_nxt = data_byte;
        for (int i = 0; i < 7; i++) held_nxt[i] = '0;
        vleft_nxt = '0;
        vacc_nxt = '0;
        sstart_nxt = '0;
        slen_nxt = '0;
        pad_nxt = '0;
        rleft_nxt = '0;
        skip_nxt = '0;
        case (data_byte) inside
          TYPE_PADDING: begin
            pad_nxt = off_t'(1);
            phase_nxt = PH_PAD;
          end
          TYPE_PING, TYPE_HS_DONE: rc = RC_DONE;
          TYPE_ACK, TYPE_ACK_ECN, TYPE_CRYPTO, [TYPE_STREAM_LO:TYPE_STREAM_HI],
          TYPE_CLOSE, TYPE_APP_CLOSE: phase_nxt = PH_SLOT0;
          TYPE_TOKEN: phase_nxt = PH_LEN;
          default: rc = RC_UNK;
        endcase
      end else if (phase_nxt == PH_SKIP) begin
        skip_nxt = skip_nxt - off_t'(1);
        if (skip_nxt == '0) rc = RC_DONE;
      end else if (phase_nxt != PH_TOEND && phase_nxt != PH_PAD) begin
        // varint: two-bit prefix gives the count of trailing bytes
        if (vleft_nxt == '0) begin
          vleft_nxt = 3'((4'd1 << data_byte[7:6]) - 4'd1);
          vacc_nxt = val_t'(data_byte[5:0]);
        end else begin
          vacc_nxt = {vacc_nxt[ValWidth-9:0], data_byte};
          vleft_nxt = vleft_nxt - 3'd1;
        end
        if (vleft_nxt == '0) begin
          if (phase_nxt >= PH_SLOT0 && phase_nxt <= PH_SLOT6) begin
            slot = 3'(phase_nxt - PH_SLOT0);
            held_nxt[slot] = vacc_nxt;
            if (type_nxt == TYPE_ACK || type_nxt == TYPE_ACK_ECN) begin
              if (slot < 3'd3 || (slot > 3'd3 && slot < 3'd6)) begin
                phase_nxt = phase_t'(phase_nxt + 5'd1);
              end else if (slot == 3'd3) begin
                sstart_nxt = nxt;
                rleft_nxt = held_nxt[2];
                if (rleft_nxt != '0) begin
                  phase_nxt = PH_GAP;
                end else begin
                  slen_nxt = '0;
                  if (type_nxt == TYPE_ACK_ECN) phase_nxt = PH_SLOT4;
                  else rc = RC_DONE;
                end
              end else begin
                rc = RC_DONE;
              end
            end else if (type_nxt >= TYPE_STREAM_LO && type_nxt <= TYPE_STREAM_HI) begin
              if (slot == 3'd0 && type_nxt[StreamOffBit]) begin
                phase_nxt = PH_SLOT1;
              end else if (type_nxt[StreamLenBit]) begin
                phase_nxt = PH_LEN;
              end else begin
                sstart_nxt = nxt;
                phase_nxt = PH_TOEND;
              end
            end else if (slot == 3'd0 && type_nxt == TYPE_CLOSE) begin
              phase_nxt = PH_SLOT1;
            end else begin
              phase_nxt = PH_LEN;
            end
          end else if (phase_nxt == PH_GAP) begin
            phase_nxt = PH_RLEN;
          end else if (phase_nxt == PH_RLEN) begin
            rleft_nxt = rleft_nxt - val_t'(1);
            if (rleft_nxt == '0) begin
              slen_nxt = nxt - sstart_nxt;
              if (type_nxt == TYPE_ACK_ECN) phase_nxt = PH_SLOT4;
              else rc = RC_DONE;
            end else begin
              phase_nxt = PH_GAP;
            end
          end else begin
            // length field
            if ((type_nxt == TYPE_TOKEN && vacc_nxt == '0)
                || (|vacc_nxt[ValWidth-1:OffsetWidth])) begin
              rc = RC_ERR;
            end else begin
              sstart_nxt = nxt;
              slen_nxt = vacc_nxt[OffsetWidth-1:0];
              skip_nxt = vacc_nxt[OffsetWidth-1:0];
              if (vacc_nxt == '0) rc = RC_DONE;
              else phase_nxt = PH_SKIP;
            end
          end
        end
      end

      if (rc != RC_MORE) begin
        rr = mk_res(type_nxt, rc == RC_ERR, pad_nxt, held_nxt, sstart_nxt, slen_nxt);
        if (n == 2'd0) push_r0 = rr;
        else push_r1 = rr;
        n = n + 2'd1;
        phase_nxt = PH_TYPE;
        if (rc != RC_DONE) drop_nxt = !last_byte;
      end
      if (phase_nxt == PH_TYPE) vleft_nxt = '0;

      // packet ends mid-frame
      if (last_byte && phase_nxt != PH_TYPE) begin
        if (phase_nxt == PH_TOEND) slen_nxt = nxt - sstart_nxt;
        rr = mk_res(type_nxt, phase_nxt != PH_PAD && phase_nxt != PH_TOEND, pad_nxt,
                    held_nxt, sstart_nxt, slen_nxt);
        if (n == 2'd0) push_r0 = rr;
        else push_r1 = rr;
        n = n + 2'd1;
        phase_nxt = PH_TYPE;
        vleft_nxt = '0;
      end
    end
    push_cnt = in_fire ? n : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TYPE;
      type_r <= '0;
      vleft_r <= '0;
      vacc_r <= '0;
      for (int i = 0; i < 7; i++) held_r[i] <= '0;
      rleft_r <= '0;
      skip_r <= '0;
      boff_r <= '0;
      pad_r <= '0;
      sstart_r <= '0;
      slen_r <= '0;
      drop_r <= 1'b0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      type_r <= type_nxt;
      vleft_r <= vleft_nxt;
      vacc_r <= vacc_nxt;
      held_r <= held_nxt;
      rleft_r <= rleft_nxt;
      skip_r <= skip_nxt;
      boff_r <= boff_nxt;
      pad_r <= pad_nxt;
      sstart_r <= sstart_nxt;
      slen_r <= slen_nxt;
      drop_r <= drop_nxt;
    end
  end

  a_type_no_varint: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_TYPE |-> vleft_r == '0)
    else $error("varint count left over at frame start");
  a_drop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    drop_r |-> phase_r == PH_TYPE)
    else $error("dropping while a frame is open");
  a_two_on_pad: assert property (@(posedge clk) disable iff (!rst_n)
    push_cnt == 2'd2 |-> push_r0.frame_kind == KIND_PAD)
    else $error("double push without a padding run ending");
  a_drop_silent: assert property (@(posedge clk) disable iff (!rst_n)
    drop_r |-> push_cnt == 2'd0)
    else $error("result emitted while dropping packet tail");

endmodule
`default_nettype wire

/* design/qfp_queue.sv */
// short result queue between parser and output stage, up to two writes
// and one read per cycle; depends on qfp_pkg
`default_nettype none
module qfp_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [1:0]    push_cnt,
  input  qfp_pkg::res_t      push_r0,
  input  qfp_pkg::res_t      push_r1,
  output logic               room2,
  output logic               not_empty,
  input  wire logic          pop,
  output qfp_pkg::res_t      head
);
  import qfp_pkg::*;

  res_t                  slots_r [QueueDepth];
  logic [QueuePtrW-1:0]  wp_r, rp_r;
  logic [QueuePtrW:0]    cnt_r;
  logic [QueuePtrW-1:0]  wp1;

  assign wp1 = wp_r + QueuePtrW'(1);
  assign room2 = cnt_r <= (QueuePtrW+1)'(QueueDepth - 2);
  assign not_empty = cnt_r != '0;
  assign head = slots_r[rp_r];

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) slots_r[wp_r] <= push_r0;
    if (push_cnt == 2'd2) slots_r[wp1] <= push_r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      wp_r <= wp_r + QueuePtrW'(push_cnt);
      if (pop) rp_r <= rp_r + QueuePtrW'(1);
      cnt_r <= cnt_r + (QueuePtrW+1)'(push_cnt) - (QueuePtrW+1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QueuePtrW+1)'(QueueDepth))
    else $error("result queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("pop from empty result queue");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push_cnt != 2'd0 |-> room2)
    else $error("push without room");

endmodule
`default_nettype wire

/* design/qfp_back.sv */
// output register stage: takes records from the queue and holds them on
// the result channel until transferred; depends on qfp_pkg
`default_nettype none
module qfp_back (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      q_not_empty,
  input  qfp_pkg::res_t  q_head,
  output logic           q_pop,
  output logic           out_valid,
  input  wire logic      out_ready,
  output qfp_pkg::res_t  out_res
);
  import qfp_pkg::*;

  logic valid_r;
  res_t res_r;

  assign q_pop = q_not_empty && (!valid_r || out_ready);
  assign out_valid = valid_r;
  assign out_res = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!valid_r || out_ready) begin
      valid_r <= q_not_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) res_r <= q_head;
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !out_ready |=> valid_r && $stable(res_r))
    else $error("result changed while stalled");
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    !valid_r && q_not_empty |=> valid_r)
    else $error("queued record not moved to output register");
  a_empty_out: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && out_ready && !q_not_empty |=> !valid_r)
    else $error("output register valid with nothing loaded");

endmodule
`default_nettype wire

/* design/quic_frame_header_parser.sv */
// top level of the quic v1 frame header parser
// depends on qfp_pkg, qfp_front, qfp_queue, qfp_back
//
// in_ channel: one packet payload byte per transfer, in_last_byte on the
// final byte; the next byte starts a new packet at offset zero.
// out_ channel: one record per parsed frame (padding runs, ping, ack,
// crypto, token, stream, close, handshake done, unknown, or an error).
// Throughput: one byte per cycle sustained while in_ready stays high.
// A byte gives zero, one or two records; two when it ends a padding run
// and also ends the frame that it starts. The parser writes each record
// into a 4-entry queue, then into the output register driving out_.
// in_ready drops when the queue has fewer than two free entries, so a
// stalled receiver backs up through the queue into the byte stream.
// Reset (rst_n low, synchronous) returns the parser to expecting a frame
// type at packet offset zero and empties the queue and output register.
`default_nettype none
module quic_frame_header_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       out_frame_kind,
  output logic [7:0]       out_type_code,
  output logic             out_decode_error,
  output logic [61:0]      out_value_a,
  output logic [61:0]      out_value_b,
  output logic [61:0]      out_value_c,
  output logic [61:0]      out_value_d,
  output logic [61:0]      out_value_e,
  output logic [61:0]      out_value_f,
  output logic [61:0]      out_value_g,
  output logic [15:0]      out_data_offset,
  output logic [15:0]      out_data_length
);
  import qfp_pkg::*;

  logic       in_fire;
  logic [1:0] push_cnt;
  res_t       push_r0, push_r1, q_head, out_res;
  logic       room2, q_not_empty, q_pop;

  assign in_ready = room2;
  assign in_fire = in_valid && in_ready;

  qfp_front u_front (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire),
    .data_byte(in_data_byte), .last_byte(in_last_byte),
    .push_cnt(push_cnt), .push_r0(push_r0), .push_r1(push_r1)
  );

  qfp_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push_cnt(push_cnt),
    .push_r0(push_r0), .push_r1(push_r1),
    .room2(room2), .not_empty(q_not_empty), .pop(q_pop), .head(q_head)
  );

  qfp_back u_back (
    .clk(clk), .rst_n(rst_n), .q_not_empty(q_not_empty), .q_head(q_head),
    .q_pop(q_pop), .out_valid(out_valid), .out_ready(out_ready), .out_res(out_res)
  );

  assign out_frame_kind   = out_res.frame_kind;
  assign out_type_code    = out_res.type_code;
  assign out_decode_error = out_res.decode_error;
  assign out_value_a      = out_res.value_a;
  assign out_value_b      = out_res.value_b;
  assign out_value_c      = out_res.value_c;
  assign out_value_d      = out_res.value_d;
  assign out_value_e      = out_res.value_e;
  assign out_value_f      = out_res.value_f;
  assign out_value_g      = out_res.value_g;
  assign out_data_offset  = out_res.data_offset;
  assign out_data_length  = out_res.data_length;

endmodule
`default_nettype wire
